FILE: rtl/preorder_tree_depth_validator_core_macros.svh
// Assertion macros shared by the checker of the pre-order tree validator.
`ifndef PREORDER_TREE_DEPTH_VALIDATOR_CORE_MACROS_SVH
`define PREORDER_TREE_DEPTH_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define PTDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PTDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ptdv_pkg.sv
// Shared types and constants of the pre-order tree depth validator.
package ptdv_pkg;

  localparam int STACK_ENTRIES_DEF = 256;
  localparam int INDEX_BITS_DEF    = 24;
  localparam int FIELD_BITS        = 24;
  localparam int DEPTH_BITS        = 8;
  localparam int DEEP_BITS         = 9;
  localparam int DEPTH_MAX         = 255;
  localparam int LEAF_SIZE         = 1;
  localparam int TOTAL_RESET       = 1;
  localparam int QUEUE_DEPTH       = 2;
  localparam int IN_TDATA_W        = 24;
  localparam int OUT_TDATA_W       = 24;

  // One cell as it waits in the queue, with the checks that need no tree state.
  typedef struct packed {
    logic                  is_leaf;
    logic [FIELD_BITS-1:0] subtree_size;
    logic                  leaf_bad;
    logic                  size_small;
  } cell_t;

endpackage

FILE: rtl/preorder_tree_depth_validator_core.sv
// Pre-order tree depth validator: checks a flattened tree cell by cell and reports depths.
// Cells of a tree flattened in pre-order arrive one per input beat; every cell yields one
// result beat with its depth and the sticky error flag, and the result for the last cell
// (total_cells, written on cfg_wdata) also carries the verdict and the maximum depth. In the
// stack engine a cell first pops each open subtree that it closes and is then committed; the
// last cell of a tree that is still sound then pops each subtree ending at the total before
// its result is formed. Once a tree has failed, its cells pop nothing. The stack engine
// reads its stack memory once per cycle, so its pops go one at a time. A two-entry
// queue sits in front of the engine and a result register after it, so either side may stall.
// The stack memory needs no clearing after reset.
module preorder_tree_depth_validator_core #(
  parameter int STACK_ENTRIES = ptdv_pkg::STACK_ENTRIES_DEF,
  parameter int INDEX_BITS    = ptdv_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ptdv_pkg::FIELD_BITS-1:0]   cfg_wdata,     // total_cells
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ptdv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // subtree_size
  input  logic [0:0]                        s_axis_tuser,  // is_leaf
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cell_depth [7:0], error_seen [8], tree_valid [9], deepest [18:10], zeros above
  output logic [ptdv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast   // last_cell
);

  logic [ptdv_pkg::FIELD_BITS-1:0] total_cells;
  logic                            q_valid;
  logic                            q_ready;
  ptdv_pkg::cell_t                 q_cell;
  logic [ptdv_pkg::DEPTH_BITS-1:0] out_depth;
  logic                            out_error;
  logic                            out_tree_ok;
  logic [ptdv_pkg::DEEP_BITS-1:0]  out_deepest;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_cells <= ptdv_pkg::FIELD_BITS'(ptdv_pkg::TOTAL_RESET);
    end else if (cfg_we) begin
      total_cells <= cfg_wdata;
    end
  end

  ptdv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_leaf  (s_axis_tuser[0]),
    .s_size  (s_axis_tdata[ptdv_pkg::FIELD_BITS-1:0]),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cell  (q_cell)
  );

  ptdv_exec #(
    .STACK_ENTRIES (STACK_ENTRIES),
    .INDEX_BITS    (INDEX_BITS)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .total_cells (total_cells),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cell      (q_cell),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_depth   (out_depth),
    .out_error   (out_error),
    .out_last    (m_axis_tlast),
    .out_tree_ok (out_tree_ok),
    .out_deepest (out_deepest)
  );

  assign m_axis_tdata = ptdv_pkg::OUT_TDATA_W'({out_deepest, out_tree_ok, out_error,
                                                out_depth});

endmodule

FILE: rtl/ptdv_front.sv
// Input side: takes cell beats, classifies them and queues them for the stack engine.
module ptdv_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  logic                           s_leaf,
  input  logic [ptdv_pkg::FIELD_BITS-1:0] s_size,
  output logic                           q_valid,
  input  logic                           q_ready,
  output ptdv_pkg::cell_t                q_cell
);

  localparam int QD = ptdv_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int NW = $clog2(QD + 1);

  ptdv_pkg::cell_t slots [QD];
  ptdv_pkg::cell_t cell_in;
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;
  logic            push;
  logic            pop;

  always_comb begin
    cell_in.is_leaf      = s_leaf;
    cell_in.subtree_size = s_size;
    cell_in.leaf_bad     = s_leaf &&
                           (s_size != ptdv_pkg::FIELD_BITS'(ptdv_pkg::LEAF_SIZE));
    cell_in.size_small   = (s_size <= ptdv_pkg::FIELD_BITS'(ptdv_pkg::LEAF_SIZE));
  end

  assign s_ready = (count != NW'(QD));
  assign q_valid = (count != '0);
  assign q_cell  = slots[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cell_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ptdv_exec.sv
// Stack engine: pops closed subtrees, checks each cell, pushes ends and forms results.
module ptdv_exec #(
  parameter int STACK_ENTRIES = ptdv_pkg::STACK_ENTRIES_DEF,
  parameter int INDEX_BITS    = ptdv_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ptdv_pkg::FIELD_BITS-1:0]  total_cells,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  ptdv_pkg::cell_t                  q_cell,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ptdv_pkg::DEPTH_BITS-1:0]  out_depth,
  output logic                             out_error,
  output logic                             out_last,
  output logic                             out_tree_ok,
  output logic [ptdv_pkg::DEEP_BITS-1:0]   out_deepest
);

  localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int SW = $clog2(STACK_ENTRIES + 1);
  localparam int CW = ((INDEX_BITS > ptdv_pkg::FIELD_BITS) ?
                       INDEX_BITS : ptdv_pkg::FIELD_BITS) + 1;
  localparam int DB = ptdv_pkg::DEEP_BITS;

  typedef enum logic {
    S_RUN,
    S_FINAL
  } state_t;

  state_t                  state;
  logic [INDEX_BITS-1:0]   mem [STACK_ENTRIES];
  logic [INDEX_BITS-1:0]   rd_data;
  logic [INDEX_BITS-1:0]   top_reg;
  logic                    top_from_mem;
  logic [INDEX_BITS-1:0]   top;
  logic [SW-1:0]           stack_size;
  logic [SW-1:0]           stack_size_next;
  logic [SW-1:0]           size_dec;
  logic [SW-1:0]           size_inc;
  logic [SW-1:0]           high_mark;
  logic [INDEX_BITS-1:0]   position;
  logic                    failed;
  logic [ptdv_pkg::DEPTH_BITS-1:0] depth_hold;

  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [CW-1:0]           idx_x;
  logic [CW-1:0]           tot_x;
  logic [CW-1:0]           size_x;
  logic [CW-1:0]           end_x;
  logic [CW-1:0]           top_x;
  logic [DB-1:0]           size_wide;
  logic [ptdv_pkg::DEPTH_BITS-1:0] depth_sat;
  logic [ptdv_pkg::DEPTH_BITS-1:0] depth_out;
  logic                    nonempty;
  logic                    out_free;
  logic                    pop_run;
  logic                    pop_final;
  logic                    commit;
  logic                    finish;
  logic                    last;
  logic                    stale;
  logic                    too_deep;
  logic                    bad_root;
  logic                    inner_bad;
  logic                    fail_new;
  logic                    push;
  logic                    restart;
  logic                    go_final;
  logic                    emit;

  assign top      = top_from_mem ? rd_data : top_reg;
  assign nonempty = (stack_size != '0);
  assign out_free = !out_valid || out_ready;

  assign idx_x  = CW'(position);
  assign tot_x  = CW'(total_cells);
  assign size_x = CW'(q_cell.subtree_size);
  assign end_x  = idx_x + size_x;
  assign top_x  = CW'(top);

  assign size_wide = DB'(stack_size);
  assign depth_sat = (size_wide > DB'(ptdv_pkg::DEPTH_MAX)) ?
                     ptdv_pkg::DEPTH_BITS'(ptdv_pkg::DEPTH_MAX) :
                     size_wide[ptdv_pkg::DEPTH_BITS-1:0];
  assign depth_out = failed ? '0 : depth_sat;

  // Pops go one at a time; the cell is settled once its index no longer closes a subtree.
  assign pop_run   = (state == S_RUN) && q_valid && !failed && nonempty &&
                     (top == position);
  assign commit    = (state == S_RUN) && q_valid && !pop_run && out_free;
  assign pop_final = (state == S_FINAL) && nonempty && (top_x == tot_x);
  assign finish    = (state == S_FINAL) && !pop_final && out_free;
  assign q_ready   = commit;

  assign last      = (total_cells == '0) || (idx_x + CW'(1) >= tot_x);
  assign stale     = nonempty && (top < position);
  assign too_deep  = (size_wide > DB'(ptdv_pkg::DEPTH_MAX));
  assign bad_root  = (position == '0) &&
                     (q_cell.is_leaf || (size_x != tot_x));
  assign inner_bad = q_cell.size_small ||
                     ((tot_x >= idx_x) && (end_x > tot_x)) ||
                     (nonempty && (end_x > top_x)) ||
                     (stack_size >= SW'(STACK_ENTRIES));
  assign fail_new  = failed || stale || too_deep || (total_cells == '0) || bad_root ||
                     (q_cell.is_leaf ? q_cell.leaf_bad : inner_bad);
  assign push      = commit && !q_cell.is_leaf && !fail_new;
  assign restart   = (commit && last && fail_new) || finish;
  assign go_final  = commit && last && !fail_new;
  assign emit      = (commit && !go_final) || finish;

  assign size_inc = stack_size + SW'(1);

  always_comb begin
    if (restart) begin
      stack_size_next = '0;
    end else if (pop_run || pop_final) begin
      stack_size_next = stack_size - SW'(1);
    end else if (push) begin
      stack_size_next = size_inc;
    end else begin
      stack_size_next = stack_size;
    end
  end

  // The read port always fetches the entry that will be on top next cycle.
  assign size_dec = stack_size_next - SW'(1);
  assign rd_addr  = size_dec[AW-1:0];
  assign wr_addr  = stack_size[AW-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_addr] <= end_x[INDEX_BITS-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      stack_size   <= '0;
      high_mark    <= '0;
      position     <= '0;
      failed       <= 1'b0;
      top_from_mem <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      stack_size <= stack_size_next;
      if (pop_run || pop_final) begin
        top_from_mem <= 1'b1;
      end
      if (commit) begin
        failed   <= last ? 1'b0 : fail_new;
        position <= last ? '0 : position + 1'b1;
        if (push) begin
          top_reg      <= end_x[INDEX_BITS-1:0];
          top_from_mem <= 1'b0;
          if (high_mark < size_inc) begin
            high_mark <= size_inc;
          end
        end
        if (go_final) begin
          state      <= S_FINAL;
          depth_hold <= depth_out;
        end else begin
          out_depth   <= depth_out;
          out_error   <= fail_new;
          out_last    <= last;
          out_tree_ok <= 1'b0;
          out_deepest <= '0;
          if (last) begin
            high_mark <= '0;
          end
        end
      end
      if (finish) begin
        state       <= S_RUN;
        out_depth   <= depth_hold;
        out_error   <= 1'b0;
        out_last    <= 1'b1;
        out_tree_ok <= !nonempty;
        out_deepest <= nonempty ? '0 : DB'(high_mark);
        high_mark   <= '0;
        failed      <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/ptdv_checker.sv
// Port-level checks for the pre-order tree validator, bound to its top level.
`include "preorder_tree_depth_validator_core_macros.svh"

module ptdv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [ptdv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [0:0]                       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ptdv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // A verdict of a well-formed tree only ever comes with the final cell.
  `PTDV_ASSERT_NOW(a_valid_on_last, m_axis_tvalid && m_axis_tdata[9], m_axis_tlast, "tree_valid off the last cell")

  `PTDV_ASSERT_NOW(a_valid_no_error, m_axis_tvalid && m_axis_tdata[9], !m_axis_tdata[8], "tree_valid with error_seen")

  // The maximum depth is reported only with a valid tree.
  `PTDV_ASSERT_NOW(a_deepest_gated, m_axis_tvalid && !m_axis_tdata[9], m_axis_tdata[18:10] == '0, "deepest set without tree_valid")

  `PTDV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

  `PTDV_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser), "cell beat changed while stalled")

endmodule

bind preorder_tree_depth_validator_core ptdv_checker u_checker (.*);

FILE: sim/tb_preorder_tree_depth_validator_core.sv
// Self-checking testbench for the pre-order tree depth validator core.
`timescale 1ns / 100ps

module tb_preorder_tree_depth_validator_core;

  localparam int CLK_HALF_NS   = 4;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  // A stray beat would follow at worst a last cell closing every open subtree.
  localparam int DRAIN_CYCLES  = 300;
  // Ample time for the slowest correct run, even with long stalls on both sides.
  localparam int LIMIT_NS      = 4_000_000;
  localparam int PHASES        = 8;
  localparam int PHASE_CELLS   = 52;
  localparam int SRC_IDLE_PCT [4] = '{0, 73, 0, 17};
  localparam int SINK_STALL_PCT [4] = '{0, 0, 73, 17};

  typedef struct packed {
    logic [ptdv_pkg::DEPTH_BITS-1:0] cell_depth;
    logic                            error_seen;
    logic                            last_cell;
    logic                            tree_valid;
    logic [ptdv_pkg::DEEP_BITS-1:0]  deepest;
  } cell_result_t;

  typedef struct packed {
    logic                            is_leaf;
    logic [ptdv_pkg::FIELD_BITS-1:0] subtree_size;
  } node_t;

  typedef struct packed {
    logic                            set_total;
    logic [ptdv_pkg::FIELD_BITS-1:0] total;
    logic                            is_leaf;
    logic [ptdv_pkg::FIELD_BITS-1:0] size;
    logic                            pinned;
    cell_result_t                    want;
  } directed_row_t;

  localparam logic [ptdv_pkg::FIELD_BITS-1:0] FIELD_MAX = '1;

  // Unpinned rows are left to the predictor.
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    // Reset total of one: a one-cell tree can never be valid.
    '{1'b0, 24'd0, 1'b0, 24'd1, 1'b1, '{8'd0, 1'b1, 1'b1, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd0, 1'b1, 1'b1, 1'b0, 9'd0}},
    // Zero total: every cell closes a failed tree.
    '{1'b1, 24'd0, 1'b0, FIELD_MAX, 1'b1, '{8'd0, 1'b1, 1'b1, 1'b0, 9'd0}},
    // Root with two leaves.
    '{1'b1, 24'd3, 1'b0, 24'd3, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd1, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd1, 1'b0, 1'b1, 1'b1, 9'd1}},
    // Two levels, the inner subtree closing one cell before the end.
    '{1'b1, 24'd4, 1'b0, 24'd4, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b0, 24'd2, 1'b1, '{8'd1, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd2, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd1, 1'b0, 1'b1, 1'b1, 9'd2}},
    // Leaf with a size other than one.
    '{1'b1, 24'd3, 1'b0, 24'd3, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd2, 1'b1, '{8'd1, 1'b1, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd0, 1'b1, 1'b1, 1'b0, 9'd0}},
    // Inner cell running past its parent; later cells report depth zero.
    '{1'b1, 24'd5, 1'b0, 24'd5, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b0, 24'd2, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b0, 24'd3, 1'b1, '{8'd2, 1'b1, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd0, 1'b1, 1'b1, 1'b0, 9'd0}},
    // Inner cell running past the total.
    '{1'b1, 24'd3, 1'b0, 24'd3, 1'b0, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b0, 24'd5, 1'b1, '{8'd1, 1'b1, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd0, 1'b1, 1'b1, 1'b0, 9'd0}},
    // Largest total, left open and then cut short by a total of one.
    '{1'b1, FIELD_MAX, 1'b0, FIELD_MAX, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b0, 24'hFFFFFE, 1'b1, '{8'd1, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b0, 24'd0, 1'b1, 24'd1, 1'b1, '{8'd2, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{1'b1, 24'd1, 1'b0, 24'd1, 1'b1, '{8'd2, 1'b1, 1'b1, 1'b0, 9'd0}}
  };

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [ptdv_pkg::FIELD_BITS-1:0]  cfg_wdata;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [ptdv_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]                       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [ptdv_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  preorder_tree_depth_validator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow of the tree state held by the block.
  logic [ptdv_pkg::FIELD_BITS-1:0] open_ends [ptdv_pkg::STACK_ENTRIES_DEF];
  int                              open_count;
  logic [ptdv_pkg::FIELD_BITS-1:0] tree_pos;
  int                              high_mark;
  bit                              tree_failed;
  logic [ptdv_pkg::FIELD_BITS-1:0] total_cells_m;

  cell_result_t awaited [$];
  node_t        tree_buf [$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatches;
  int cells_sent;
  int beats_checked;
  int trees_valid;
  int trees_rejected;
  int deepest_valid;
  int totals_written;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("Timed out with %0d results still awaited", awaited.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic cell_result_t cell_verdict(input logic leaf,
                                                input logic [ptdv_pkg::FIELD_BITS-1:0] size);
    cell_result_t     r;
    longint unsigned  idx;
    longint unsigned  tot;
    longint unsigned  sub_end;
    bit               closing;
    r = '0;
    tot = 64'(total_cells_m);
    idx = 64'(tree_pos);
    closing = (tot == 0) || (idx + 1 >= tot);
    if (!tree_failed) begin
      while (open_count > 0 && open_ends[open_count-1] == idx)
        open_count--;
      if (open_count > 0 && open_ends[open_count-1] < idx)
        tree_failed = 1'b1;
      if (open_count > ptdv_pkg::DEPTH_MAX)
        tree_failed = 1'b1;
      r.cell_depth = ptdv_pkg::DEPTH_BITS'((open_count > ptdv_pkg::DEPTH_MAX) ?
                                           ptdv_pkg::DEPTH_MAX : open_count);
      if (tot == 0)
        tree_failed = 1'b1;
      if (idx == 0 && (leaf || size != tot))
        tree_failed = 1'b1;
      if (leaf) begin
        if (size != ptdv_pkg::LEAF_SIZE)
          tree_failed = 1'b1;
      end else if (size <= 1 || size > tot - idx) begin
        // A total lowered in mid tree makes tot - idx wrap, so the check passes as in the hardware.
        tree_failed = 1'b1;
      end else begin
        sub_end = idx + size;
        if (open_count > 0 && sub_end > open_ends[open_count-1])
          tree_failed = 1'b1;
        else if (open_count >= ptdv_pkg::STACK_ENTRIES_DEF)
          tree_failed = 1'b1;
        if (!tree_failed) begin
          open_ends[open_count] = ptdv_pkg::FIELD_BITS'(sub_end);
          open_count++;
          if (high_mark < open_count)
            high_mark = open_count;
        end
      end
    end
    if (closing && !tree_failed) begin
      while (open_count > 0 && open_ends[open_count-1] == tot)
        open_count--;
      if (open_count == 0) begin
        r.tree_valid = 1'b1;
        r.deepest = ptdv_pkg::DEEP_BITS'(high_mark);
      end
    end
    r.error_seen = tree_failed;
    r.last_cell = closing;
    if (closing) begin
      open_count = 0;
      tree_pos = '0;
      high_mark = 0;
      tree_failed = 1'b0;
    end else begin
      tree_pos = tree_pos + 1'b1;
    end
    return r;
  endfunction

  task automatic log_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic send_cell(input logic leaf, input logic [ptdv_pkg::FIELD_BITS-1:0] size,
                           input bit pinned, input cell_result_t pin);
    cell_result_t v;
    v = cell_verdict(leaf, size);
    if (pinned)
      v = pin;
    awaited.insert(awaited.size(), v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= size;
    s_axis_tuser <= leaf;
    do @(posedge clk); while (!s_axis_tready);
    cells_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic [ptdv_pkg::FIELD_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    total_cells_m = value;
    totals_written++;
  endtask

  // Builds a well-formed pre-order tree of n cells; a chain nests every cell in the last.
  task automatic grow_tree(input int n, input bit chain);
    int budget [$];
    int b;
    int c;
    tree_buf.delete();
    tree_buf.insert(tree_buf.size(), '{1'b0, 24'(n)});
    budget.insert(budget.size(), n - 1);
    while (budget.size() > 0) begin
      b = budget[$];
      if (b == 0) begin
        budget.delete(budget.size() - 1);
      end else begin
        if (chain || $urandom_range(0, 2) == 0)
          c = b;
        else
          c = $urandom_range(1, (b < 5) ? b : 5);
        budget[$] = b - c;
        tree_buf.insert(tree_buf.size(), '{c == 1, 24'(c)});
        if (c > 1)
          budget.insert(budget.size(), c - 1);
      end
    end
  endtask

  // Most trees pass untouched; some get one broken cell and a few are pure noise.
  task automatic roughen_tree();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      for (k = 0; k < tree_buf.size(); k++) begin
        tree_buf[k].is_leaf = 1'($urandom_range(0, 1));
        tree_buf[k].subtree_size = $urandom_range(0, 1) ? 24'($urandom)
                                                        : 24'($urandom_range(0, 8));
      end
    end else if (pick < 30) begin
      k = $urandom_range(0, tree_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: tree_buf[k].is_leaf = ~tree_buf[k].is_leaf;
        1: tree_buf[k].subtree_size = tree_buf[k].subtree_size +
                                      ($urandom_range(0, 1) ? 24'd1 : FIELD_MAX);
        default: tree_buf[k].subtree_size = 24'($urandom);
      endcase
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited.size() == 0) begin
        log_mismatch("result beat with no cell outstanding");
      end else begin
        want = awaited.pop_front();
        beats_checked++;
        if (m_axis_tdata[7:0] !== want.cell_depth)
          log_mismatch($sformatf("beat %0d cell_depth %0d, expected %0d", beats_checked,
                                 m_axis_tdata[7:0], want.cell_depth));
        if (m_axis_tdata[8] !== want.error_seen)
          log_mismatch($sformatf("beat %0d error_seen %b, expected %b", beats_checked,
                                 m_axis_tdata[8], want.error_seen));
        if (m_axis_tlast !== want.last_cell)
          log_mismatch($sformatf("beat %0d last_cell %b, expected %b", beats_checked,
                                 m_axis_tlast, want.last_cell));
        if (m_axis_tdata[9] !== want.tree_valid)
          log_mismatch($sformatf("beat %0d tree_valid %b, expected %b", beats_checked,
                                 m_axis_tdata[9], want.tree_valid));
        if (m_axis_tdata[18:10] !== want.deepest)
          log_mismatch($sformatf("beat %0d deepest %0d, expected %0d", beats_checked,
                                 m_axis_tdata[18:10], want.deepest));
        if (want.last_cell && want.tree_valid) begin
          trees_valid++;
          if (want.deepest > deepest_valid)
            deepest_valid = int'(want.deepest);
        end else if (want.last_cell) begin
          trees_rejected++;
        end
      end
    end
  end

  initial begin : stimulus
    int  p;
    int  n;
    int  k;
    int  keep;
    int  in_phase;
    bit  deep_run;
    mismatches = 0;
    cells_sent = 0;
    beats_checked = 0;
    trees_valid = 0;
    trees_rejected = 0;
    deepest_valid = 0;
    totals_written = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    open_count = 0;
    tree_pos = '0;
    high_mark = 0;
    tree_failed = 1'b0;
    total_cells_m = ptdv_pkg::FIELD_BITS'(ptdv_pkg::TOTAL_RESET);
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].set_total) begin
        wait_idle();
        write_total(DIRECTED_ROWS[i].total);
      end
      send_cell(DIRECTED_ROWS[i].is_leaf, DIRECTED_ROWS[i].size,
                DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      src_idle_pct = SRC_IDLE_PCT[p % 4];
      sink_stall_pct = SINK_STALL_PCT[p % 4];
      // A tree left open by the last phase is closed by one cell under a total of one.
      if (tree_pos != 0) begin
        write_total(ptdv_pkg::FIELD_BITS'(ptdv_pkg::TOTAL_RESET));
        send_cell(1'b0, 24'($urandom), 1'b0, '0);
        wait_idle();
      end
      // Two phases run a single chain: one reaches depth 255, the other overflows it.
      deep_run = (p == 2) || (p == 4);
      n = (p == 2) ? ptdv_pkg::DEPTH_MAX + 1 :
          (p == 4) ? ptdv_pkg::DEPTH_MAX + 3 : $urandom_range(2, (p % 2) ? 40 : 9);
      write_total(24'(n));
      in_phase = 0;
      while (in_phase < PHASE_CELLS) begin
        grow_tree(n, deep_run);
        if (!deep_run)
          roughen_tree();
        keep = tree_buf.size();
        // Odd phases stop in mid tree, so the next total is written under an open tree.
        if (p % 2 == 1 && in_phase + keep >= PHASE_CELLS)
          keep = $urandom_range(1, keep - 1);
        for (k = 0; k < keep; k++)
          send_cell(tree_buf[k].is_leaf, tree_buf[k].subtree_size, 1'b0, '0);
        in_phase += keep;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d cells under %0d total settings; checked %0d result beats.",
             cells_sent, totals_written, beats_checked);
    $display("Trees closed: %0d valid (deepest %0d), %0d rejected; %0d mismatches.",
             trees_valid, deepest_valid, trees_rejected, mismatches);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
